>>> hw/rtl/cbr_pkg.sv
// Shared types and constants for the cubic bisection root unit.
// Used by the controller, the datapath and the top level; no dependencies.
package cbr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_STEPS = 64;
  localparam int PROD_W    = 96;
  localparam int Q_W       = PROD_W - FRAC_BITS + 1;
  localparam int STEP_W    = 7;

  localparam logic [2:0] CFG_CUBE     = 3'd0;
  localparam logic [2:0] CFG_SQUARE   = 3'd1;
  localparam logic [2:0] CFG_LINEAR   = 3'd2;
  localparam logic [2:0] CFG_CONSTANT = 3'd3;
  localparam logic [2:0] CFG_TOL      = 3'd4;

  localparam logic [1:0] OUT_CONVERGED = 2'd0;
  localparam logic [1:0] OUT_EXACT     = 2'd1;
  localparam logic [1:0] OUT_NO_ROOT   = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SEL, OP_MAG, OP_MLO, OP_MHI, OP_COMB, OP_ACC,
    OP_SAVE_FA, OP_SAVE_FB, OP_EXACT, OP_UPDATE, OP_NOROOT, OP_EMIT
  } dp_op_e;

  typedef enum logic [1:0] {
    TGT_A, TGT_B, TGT_C
  } tgt_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEL, ST_MAG, ST_MLO, ST_MHI, ST_COMB, ST_ACC,
    ST_CHECK, ST_TEST, ST_LOOP, ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e     op;
    tgt_e       tgt;
    logic [1:0] term;
  } dp_cmd_t;

  typedef struct packed {
    logic same_sign;
    logic width_open;
    logic steps_left;
    logic fc_zero;
  } dp_status_t;

endpackage

>>> hw/rtl/cubic_bisection_root_unit.sv
// Cubic bisection root unit, one result per interval. It evaluates both ends and tests their
// signs, then per halving runs a Horner pass on the shared 32x32 multiplier, an update and a
// test, then a last width test unless an exact zero ends the search, and then loads the
// result register.
// Throughput: one item at a time; the next is taken once the result is loaded.
// Reset: asynchronous, active low; clears control and restores register defaults.
module cubic_bisection_root_unit import cbr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] interval_low_i,
  input  logic signed [31:0] interval_high_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] root_value_o,
  output logic [1:0]         outcome_o,
  output logic [STEP_W-1:0]  halvings_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic signed [31:0] cube_q, square_q, linear_q, const_q;
  logic [30:0]        tol_q;
  dp_cmd_t            cmd;
  dp_status_t         status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cube_q   <= 32'sd0;
      square_q <= 32'sd0;
      linear_q <= 32'sd65536;
      const_q  <= 32'sd0;
      tol_q    <= 31'd66;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CUBE:     cube_q   <= cfg_data_i;
        CFG_SQUARE:   square_q <= cfg_data_i;
        CFG_LINEAR:   linear_q <= cfg_data_i;
        CFG_CONSTANT: const_q  <= cfg_data_i;
        CFG_TOL:      tol_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  cbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cbr_datapath u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .interval_low_i  (interval_low_i),
    .interval_high_i (interval_high_i),
    .coef_cube_i     (cube_q),
    .coef_square_i   (square_q),
    .coef_linear_i   (linear_q),
    .coef_constant_i (const_q),
    .tolerance_i     (tol_q),
    .root_value_o    (root_value_o),
    .outcome_o       (outcome_o),
    .halvings_o      (halvings_o)
  );

  a_no_root_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OUT_NO_ROOT) |-> (root_value_o == 32'sd0)
      && (halvings_o == '0))
    else $error("no-root result carries a value");

  a_step_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (halvings_o <= STEP_W'(MAX_STEPS)))
    else $error("halving count beyond cap");

  a_exact_has_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OUT_EXACT) |-> (halvings_o != '0))
    else $error("exact zero reported without a halving");

endmodule

>>> hw/rtl/cbr_datapath.sv
// Datapath of the bisection unit: interval registers, Horner evaluator
// with one shared 32x32 multiplier, and the result registers. Uses cbr_pkg.
module cbr_datapath import cbr_pkg::*; (
  input  logic               clk_i,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  input  logic signed [31:0] interval_low_i,
  input  logic signed [31:0] interval_high_i,
  input  logic signed [31:0] coef_cube_i,
  input  logic signed [31:0] coef_square_i,
  input  logic signed [31:0] coef_linear_i,
  input  logic signed [31:0] coef_constant_i,
  input  logic [30:0]        tolerance_i,
  output logic signed [31:0] root_value_o,
  output logic [1:0]         outcome_o,
  output logic [STEP_W-1:0]  halvings_o
);

  logic signed [31:0] a_q, a_d, b_q, b_d, c_q, c_d, x_q, x_d;
  logic signed [63:0] acc_q, acc_d;
  logic [63:0]        ua_q, ua_d, plo_q, plo_d, phi_q, phi_d;
  logic [31:0]        ub_q, ub_d;
  logic               neg_q, neg_d;
  logic [Q_W-1:0]     qm_q, qm_d;
  logic [1:0]         fa_sgn_q, fa_sgn_d, fb_sgn_q, fb_sgn_d;
  logic [1:0]         outc_q, outc_d;
  logic [STEP_W-1:0]  steps_q, steps_d;
  logic signed [31:0] root_q, root_d;
  logic [1:0]         res_out_q, res_out_d;
  logic [STEP_W-1:0]  res_steps_q, res_steps_d;

  logic signed [32:0] in_sum, ab_sum, diff;
  logic [32:0]        diff_mag;
  logic [PROD_W-1:0]  prod;
  logic signed [63:0] mq;
  logic signed [64:0] sum65;
  logic signed [31:0] coef_sel;
  logic [1:0]         acc_sgn;

  assign in_sum  = {interval_low_i[31], interval_low_i} + {interval_high_i[31], interval_high_i};
  assign ab_sum  = {a_q[31], a_q} + {b_q[31], b_q};
  assign diff    = {b_q[31], b_q} - {a_q[31], a_q};
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  // Sign code: {negative, zero}.
  assign acc_sgn = {acc_q[63], acc_q == 64'sd0};
  assign prod    = {32'b0, plo_q} + {phi_q, 32'b0};

  always_comb begin
    case (cmd_i.term)
      2'd0:    coef_sel = coef_square_i;
      2'd1:    coef_sel = coef_linear_i;
      default: coef_sel = coef_constant_i;
    endcase
    // Clamp the rounded magnitude into the signed 64-bit range.
    if (|qm_q[Q_W-1:63]) begin
      mq = neg_q ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      mq = neg_q ? -$signed({1'b0, qm_q[62:0]}) : $signed({1'b0, qm_q[62:0]});
    end
    sum65 = {mq[63], mq} + {{33{coef_sel[31]}}, coef_sel};
  end

  always_comb begin
    a_d = a_q; b_d = b_q; c_d = c_q; x_d = x_q; acc_d = acc_q;
    ua_d = ua_q; ub_d = ub_q; neg_d = neg_q; plo_d = plo_q; phi_d = phi_q;
    qm_d = qm_q; fa_sgn_d = fa_sgn_q; fb_sgn_d = fb_sgn_q;
    outc_d = outc_q; steps_d = steps_q;
    root_d = root_q; res_out_d = res_out_q; res_steps_d = res_steps_q;
    case (cmd_i.op)
      OP_LOAD: begin
        a_d = interval_low_i;
        b_d = interval_high_i;
        c_d = in_sum[32:1];
        steps_d = '0;
        outc_d = OUT_CONVERGED;
      end
      OP_SEL: begin
        acc_d = 64'(coef_cube_i);
        case (cmd_i.tgt)
          TGT_A:   x_d = a_q;
          TGT_B:   x_d = b_q;
          default: begin
            x_d = ab_sum[32:1];
            c_d = ab_sum[32:1];
            steps_d = steps_q + STEP_W'(1);
          end
        endcase
      end
      OP_MAG: begin
        ua_d  = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
        ub_d  = x_q[31] ? 32'(-x_q) : 32'(x_q);
        neg_d = acc_q[63] ^ x_q[31];
      end
      OP_MLO: plo_d = ua_q[31:0] * ub_q;
      OP_MHI: phi_d = ua_q[63:32] * ub_q;
      OP_COMB: begin
        // Negative products round toward minus infinity: bump the magnitude.
        qm_d = {1'b0, prod[PROD_W-1:FRAC_BITS]}
             + Q_W'(neg_q & (|prod[FRAC_BITS-1:0]));
      end
      OP_ACC: begin
        if (sum65[64] != sum65[63]) begin
          acc_d = sum65[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
          acc_d = sum65[63:0];
        end
      end
      OP_SAVE_FA: fa_sgn_d = acc_sgn;
      OP_SAVE_FB: fb_sgn_d = acc_sgn;
      OP_EXACT:   outc_d = OUT_EXACT;
      OP_UPDATE: begin
        if (acc_sgn == fa_sgn_q) a_d = c_q;
        else                     b_d = c_q;
      end
      OP_NOROOT:  outc_d = OUT_NO_ROOT;
      OP_EMIT: begin
        res_out_d = outc_q;
        root_d = (outc_q == OUT_NO_ROOT) ? 32'sd0 : c_q;
        res_steps_d = (outc_q == OUT_NO_ROOT) ? '0 : steps_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; c_q <= c_d; x_q <= x_d; acc_q <= acc_d;
    ua_q <= ua_d; ub_q <= ub_d; neg_q <= neg_d; plo_q <= plo_d; phi_q <= phi_d;
    qm_q <= qm_d; fa_sgn_q <= fa_sgn_d; fb_sgn_q <= fb_sgn_d;
    outc_q <= outc_d; steps_q <= steps_d;
    root_q <= root_d; res_out_q <= res_out_d; res_steps_q <= res_steps_d;
  end

  assign status_o.same_sign  = (fa_sgn_q == fb_sgn_q);
  assign status_o.width_open = (diff_mag >= {2'b0, tolerance_i});
  assign status_o.steps_left = (steps_q < STEP_W'(MAX_STEPS));
  assign status_o.fc_zero    = acc_sgn[0];

  assign root_value_o = root_q;
  assign outcome_o    = res_out_q;
  assign halvings_o   = res_steps_q;

endmodule

>>> hw/rtl/cbr_ctrl.sv
// Controller of the bisection unit: sequences the Horner steps and the
// bisection loop, and owns the output valid flag. Uses cbr_pkg.
module cbr_ctrl import cbr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  tgt_e        tgt_q, tgt_d;
  logic [1:0]  term_q, term_d;
  logic        ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tgt_q    <= TGT_A;
      term_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      tgt_q    <= tgt_d;
      term_q   <= term_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    tgt_d = tgt_q;
    term_d = term_q;
    ovalid_d = ovalid_q && out_stall_i;
    cmd_o.op = OP_NONE;
    cmd_o.tgt = tgt_q;
    cmd_o.term = term_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          tgt_d = TGT_A;
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        cmd_o.op = OP_SEL;
        term_d = '0;
        state_d = ST_MAG;
      end
      ST_MAG: begin cmd_o.op = OP_MAG; state_d = ST_MLO; end
      ST_MLO: begin cmd_o.op = OP_MLO; state_d = ST_MHI; end
      ST_MHI: begin cmd_o.op = OP_MHI; state_d = ST_COMB; end
      ST_COMB: begin cmd_o.op = OP_COMB; state_d = ST_ACC; end
      ST_ACC: begin
        cmd_o.op = OP_ACC;
        if (term_q == 2'd2) begin
          state_d = ST_CHECK;
        end else begin
          term_d = term_q + 2'd1;
          state_d = ST_MAG;
        end
      end
      ST_CHECK: begin
        case (tgt_q)
          TGT_A: begin
            cmd_o.op = OP_SAVE_FA;
            tgt_d = TGT_B;
            state_d = ST_SEL;
          end
          TGT_B: begin
            cmd_o.op = OP_SAVE_FB;
            state_d = ST_TEST;
          end
          default: begin
            if (status_i.fc_zero) begin
              cmd_o.op = OP_EXACT;
              state_d = ST_DONE;
            end else begin
              cmd_o.op = OP_UPDATE;
              state_d = ST_LOOP;
            end
          end
        endcase
      end
      ST_TEST: begin
        if (status_i.same_sign) begin
          cmd_o.op = OP_NOROOT;
          state_d = ST_DONE;
        end else begin
          state_d = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (status_i.width_open && status_i.steps_left) begin
          tgt_d = TGT_C;
          state_d = ST_SEL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // The result register takes a new transfer once the old one is gone.
        if (!ovalid_q || !out_stall_i) begin
          cmd_o.op = OP_EMIT;
          ovalid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = ovalid_q;

endmodule
